// ===== rtl/core/rsti_pkg.sv =====
// rsti_pkg: shared types and constants of the radix string-to-integer parser
// used by rsti_decode, rsti_accum and radix_string_to_integer
package rsti_pkg;

	// field widths
	localparam int CHAR_W  = 16;
	localparam int RADIX_W = 6;
	localparam int VALUE_W = 64;
	localparam int ERR_W   = 2;
	localparam int DIGIT_W = 6;

	// configuration register indexes
	localparam logic REG_RADIX     = 1'b0;
	localparam logic REG_WIDE_MODE = 1'b1;

	// register reset values
	localparam logic [RADIX_W-1:0] RADIX_RESET     = 6'd10;
	localparam logic               WIDE_MODE_RESET = 1'b0;

	// legal radix range
	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

	// error codes
	localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
	localparam logic [ERR_W-1:0] ERR_BAD_RADIX = 2'd1;
	localparam logic [ERR_W-1:0] ERR_ILLEGAL   = 2'd2;
	localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd3;

	// character codes
	localparam logic [CHAR_W-1:0] CH_ZERO   = 16'h0030;
	localparam logic [CHAR_W-1:0] CH_NINE   = 16'h0039;
	localparam logic [CHAR_W-1:0] CH_LA     = 16'h0061;
	localparam logic [CHAR_W-1:0] CH_LZ     = 16'h007A;
	localparam logic [CHAR_W-1:0] CH_UA     = 16'h0041;
	localparam logic [CHAR_W-1:0] CH_UZ     = 16'h005A;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 16'h002D;
	localparam logic [CHAR_W-1:0] CH_PLUS   = 16'h002B;
	localparam logic [CHAR_W-1:0] ASCII_TOP = 16'd128;
	localparam logic [DIGIT_W-1:0] DIGIT_LETTER_BASE = 6'd10;

	// negative limits, in the width of the overflow compare
	localparam int CMP_W = 72;
	localparam logic signed [CMP_W-1:0] LIM64_NEG = -72'sh8000000000000000;
	localparam logic signed [CMP_W-1:0] LIM64_POS = -72'sh7FFFFFFFFFFFFFFF;
	localparam logic signed [CMP_W-1:0] LIM32_NEG = -72'sh80000000;
	localparam logic signed [CMP_W-1:0] LIM32_POS = -72'sh7FFFFFFF;

	// classification of one character
	typedef struct packed {
		logic               below_zero;
		logic               is_minus;
		logic               is_plus;
		logic               digit_ok;
		logic [DIGIT_W-1:0] digit;
	} char_info_t;

	// one result item
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [ERR_W-1:0]          error_code;
	} result_t;

endpackage

// ===== rtl/core/rsti_ifs.sv =====
// rsti_ifs: valid/ready channel interfaces of the radix string-to-integer parser
// character input, result output and configuration write; no dependencies
interface rsti_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] char_code;
	logic        last_char;

	modport source (output valid, char_code, last_char, input ready);
	modport sink (input valid, char_code, last_char, output ready);
endinterface

interface rsti_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] value;
	logic [1:0]         error_code;

	modport source (output valid, value, error_code, input ready);
	modport sink (input valid, value, error_code, output ready);
endinterface

interface rsti_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [5:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/rsti_decode.sv =====
// rsti_decode: classifies one character as sign, digit or illegal under a radix
// depends on rsti_pkg
module rsti_decode (
	input  logic [15:0]          char_code,
	input  logic [5:0]           radix,
	output rsti_pkg::char_info_t info
);
	import rsti_pkg::*;

	logic [DIGIT_W-1:0] dval;
	logic               hit;

	// digit value of 0-9, a-z, A-Z
	always_comb begin
		dval = '0;
		hit  = 1'b0;
		if (char_code < ASCII_TOP) begin
			if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
				dval = DIGIT_W'(char_code - CH_ZERO);
				hit  = 1'b1;
			end else if (char_code >= CH_LA && char_code <= CH_LZ) begin
				dval = DIGIT_LETTER_BASE + DIGIT_W'(char_code - CH_LA);
				hit  = 1'b1;
			end else if (char_code >= CH_UA && char_code <= CH_UZ) begin
				dval = DIGIT_LETTER_BASE + DIGIT_W'(char_code - CH_UA);
				hit  = 1'b1;
			end
		end
	end

	// pack the classification
	always_comb begin
		info.below_zero = char_code < CH_ZERO;
		info.is_minus   = char_code == CH_MINUS;
		info.is_plus    = char_code == CH_PLUS;
		info.digit_ok   = hit && (dval < radix);
		info.digit      = dval;
	end

endmodule

// ===== rtl/core/rsti_accum.sv =====
// rsti_accum: string state (negative accumulator, sign, start, sticky error)
// and the per-character multiply, subtract and overflow check; depends on rsti_pkg
module rsti_accum (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic                 last,
	input  rsti_pkg::char_info_t info,
	input  logic [5:0]           radix,
	input  logic                 wide_mode,
	output rsti_pkg::result_t    result
);
	import rsti_pkg::*;

	logic signed [VALUE_W-1:0] acc_q, acc_n, mag;
	logic                      neg_q, neg_n;
	logic                      start_q;
	logic [ERR_W-1:0]          err_q, err_n;
	logic                      radix_bad;
	logic signed [CMP_W-2:0]   prod;
	logic signed [CMP_W-1:0]   cand;
	logic signed [CMP_W-1:0]   limit;
	logic                      ovf;

	// acc * radix - digit, checked against the limit in full width
	always_comb begin
		radix_bad = (radix < RADIX_MIN) || (radix > RADIX_MAX);
		prod = (CMP_W-1)'(acc_q) * (CMP_W-1)'($signed({1'b0, radix}));
		cand = CMP_W'(prod) - CMP_W'($signed({1'b0, info.digit}));
		case ({wide_mode, neg_q})
			2'b11:   limit = LIM64_NEG;
			2'b10:   limit = LIM64_POS;
			2'b01:   limit = LIM32_NEG;
			default: limit = LIM32_POS;
		endcase
		ovf = cand < limit;
	end

	// next string state
	always_comb begin
		acc_n = acc_q;
		neg_n = neg_q;
		err_n = err_q;
		if (err_q == ERR_NONE) begin
			if (radix_bad) begin
				err_n = ERR_BAD_RADIX;
			end else if (start_q && info.below_zero) begin
				if (info.is_minus) begin
					neg_n = 1'b1;
				end else if (!info.is_plus) begin
					err_n = ERR_ILLEGAL;
				end
			end else if (!info.digit_ok) begin
				err_n = ERR_ILLEGAL;
			end else if (ovf) begin
				err_n = ERR_OVERFLOW;
			end else begin
				acc_n = cand[VALUE_W-1:0];
			end
		end
	end

	// result of a string ending on this item
	always_comb begin
		mag = neg_n ? acc_n : -acc_n;
		result.error_code = err_n;
		if (err_n != ERR_NONE) begin
			result.value = '0;
		end else if (wide_mode) begin
			result.value = mag;
		end else begin
			result.value = {{(VALUE_W-32){mag[31]}}, mag[31:0]};
		end
	end

	// state registers, cleared after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			neg_q   <= 1'b0;
			start_q <= 1'b1;
			err_q   <= ERR_NONE;
		end else if (fire) begin
			if (last) begin
				acc_q   <= '0;
				neg_q   <= 1'b0;
				start_q <= 1'b1;
				err_q   <= ERR_NONE;
			end else begin
				acc_q   <= acc_n;
				neg_q   <= neg_n;
				start_q <= 1'b0;
				err_q   <= err_n;
			end
		end
	end

endmodule

// ===== rtl/core/radix_string_to_integer.sv =====
// radix_string_to_integer: top level of the radix string-to-integer parser
// depends on rsti_pkg, rsti_ifs, rsti_decode and rsti_accum
//
// Takes one character of a number string per cycle on chars, with last_char
// closing the string, and returns one result item (value, error_code) per
// string on results. A new character is accepted every cycle unless the
// last character of a string waits in the input register for a full output
// register; the result of a string is valid in the output register the cycle
// after its last character leaves the input register. This rate is set by
// the accumulator loop: one multiply by the radix, one subtract and one
// limit compare per character. radix and wide_mode are written on cfg
// (index 0 and 1) and are meant to change only while the block is idle.
module radix_string_to_integer (
	input logic         clk,
	input logic         arst_n,
	rsti_in_if.sink     chars,
	rsti_out_if.source  results,
	rsti_cfg_if.sink    cfg
);
	import rsti_pkg::*;

	logic [RADIX_W-1:0] radix_q;
	logic               wide_q;
	logic               valid_s1;
	logic [CHAR_W-1:0]  char_s1;
	logic               last_s1;
	logic               out_valid_q;
	result_t            out_q;
	logic               out_free;
	logic               adv_s1;
	char_info_t         info;
	result_t            result;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
			wide_q  <= WIDE_MODE_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_RADIX:     radix_q <= cfg.data;
				REG_WIDE_MODE: wide_q  <= cfg.data[0];
				default:       ;
			endcase
		end
	end

	// handshake: an item leaves s1 unless it ends a string and the output is full
	assign out_free    = !out_valid_q || results.ready;
	assign adv_s1      = valid_s1 && (!last_s1 || out_free);
	assign chars.ready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_code;
			last_s1 <= chars.last_char;
		end
	end

	// character classification and string state
	rsti_decode u_decode (
		.char_code (char_s1),
		.radix     (radix_q),
		.info      (info)
	);

	rsti_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (adv_s1),
		.last      (last_s1),
		.info      (info),
		.radix     (radix_q),
		.wide_mode (wide_q),
		.result    (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			out_q <= result;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.value      = out_q.value;
	assign results.error_code = out_q.error_code;

	// a failed string reports value zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.error_code != ERR_NONE |-> out_q.value == '0)
		else $error("error result with nonzero value");

	// a good result in 32-bit mode is sign extended
	a_narrow_ext: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !wide_q && out_q.error_code == ERR_NONE
		|-> out_q.value[VALUE_W-1:32] == {(VALUE_W-32){out_q.value[31]}})
		else $error("32-bit result not sign extended");

	// the last character of a string always produces a result next cycle
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> out_valid_q)
		else $error("string end without result");

	// a string end never leaves s1 while the output holds an untaken item
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !results.ready |-> !(adv_s1 && last_s1))
		else $error("result overwritten");

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench of radix_string_to_integer
// depends on rsti_pkg, rsti_ifs and the radix_string_to_integer rtl
`timescale 1ns / 1ps

module tb_top;
	import rsti_pkg::*;

	typedef logic [CHAR_W-1:0] char_q_t[$];

	// characters used in directed strings that the package does not name
	localparam logic [CHAR_W-1:0] CH_STAR = 16'h002A;
	localparam logic [CHAR_W-1:0] CH_BANG = 16'h0021;

	// cycles to let the pipeline empty when no result is outstanding
	localparam int SETTLE_CYCLES = 6;

	logic clk = 1'b0;
	logic arst_n;

	rsti_in_if  chars_if ();
	rsti_out_if res_if ();
	rsti_cfg_if cfg_if ();

	radix_string_to_integer i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.results (res_if),
		.cfg     (cfg_if)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// idling of both channels, in percent
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	int errors     = 0;
	int chars_sent = 0;

	// register shadow and string state of the parser
	logic [RADIX_W-1:0] radix_cfg = RADIX_RESET;
	logic               wide_cfg  = WIDE_MODE_RESET;
	longint             str_acc   = 0;
	logic               str_neg   = 1'b0;
	logic               str_first = 1'b1;
	logic [ERR_W-1:0]   str_err   = ERR_NONE;

	result_t pending_results[$];
	result_t want;

	// digit value of a character under a base, -1 when it is no digit
	function automatic longint char_digit(logic [CHAR_W-1:0] ch, longint base);
		longint d;
		d = -1;
		if (ch >= ASCII_TOP)
			return -1;
		if (ch >= CH_ZERO && ch <= CH_NINE)
			d = longint'(ch - CH_ZERO);
		else if (ch >= CH_LA && ch <= CH_LZ)
			d = longint'(DIGIT_LETTER_BASE) + longint'(ch - CH_LA);
		else if (ch >= CH_UA && ch <= CH_UZ)
			d = longint'(DIGIT_LETTER_BASE) + longint'(ch - CH_UA);
		return (d < base) ? d : -1;
	endfunction

	// one character into the negative accumulator, no error held
	function automatic void parse_char(logic [CHAR_W-1:0] ch);
		logic   first;
		longint base;
		longint lim;
		longint multmin;
		longint d;
		first     = str_first;
		str_first = 1'b0;
		if (radix_cfg < RADIX_MIN || radix_cfg > RADIX_MAX) begin
			str_err = ERR_BAD_RADIX;
			return;
		end
		base = longint'(radix_cfg);
		// leading sign or junk below the digits
		if (first && ch < CH_ZERO) begin
			if (ch == CH_MINUS)
				str_neg = 1'b1;
			else if (ch != CH_PLUS)
				str_err = ERR_ILLEGAL;
			return;
		end
		if (wide_cfg)
			lim = str_neg ? 64'sh8000_0000_0000_0000 : -64'sh7FFF_FFFF_FFFF_FFFF;
		else
			lim = str_neg ? -64'sd2147483648 : -64'sd2147483647;
		multmin = lim / base;
		d = char_digit(ch, base);
		// bad digit wins over overflow
		if (d < 0) begin
			str_err = ERR_ILLEGAL;
			return;
		end
		if (str_acc < multmin) begin
			str_err = ERR_OVERFLOW;
			return;
		end
		str_acc = str_acc * base;
		if (str_acc < lim + d) begin
			str_err = ERR_OVERFLOW;
			return;
		end
		str_acc = str_acc - d;
	endfunction

	// expected result of one accepted item, if it closes a string
	function automatic void predict_char(logic [CHAR_W-1:0] ch, logic last);
		result_t      r;
		logic [63:0]  v;
		if (str_err == ERR_NONE)
			parse_char(ch);
		else
			str_first = 1'b0;
		if (!last)
			return;
		if (str_err != ERR_NONE) begin
			v = '0;
		end else begin
			v = str_neg ? str_acc : -str_acc;
			if (!wide_cfg)
				v = {{32{v[31]}}, v[31:0]};
		end
		r.value      = v;
		r.error_code = str_err;
		pending_results.push_back(r);
		str_acc   = 0;
		str_neg   = 1'b0;
		str_first = 1'b1;
		str_err   = ERR_NONE;
	endfunction

	// character for a digit value, letters in random case
	function automatic logic [CHAR_W-1:0] digit_char(int d);
		if (d < 10)
			return CH_ZERO + 16'(d);
		return ($urandom_range(1) ? CH_LA : CH_UA) + 16'(d - 10);
	endfunction

	// digits of a magnitude in a base, most significant first
	function automatic char_q_t number_chars(logic [63:0] mag, logic [63:0] base);
		char_q_t s;
		do begin
			s.push_front(digit_char(int'(mag % base)));
			mag = mag / base;
		end while (mag != 0);
		return s;
	endfunction

	// any kind of character: wide codes, ascii, signs, digits
	function automatic logic [CHAR_W-1:0] noise_char();
		case ($urandom_range(4))
			0: return 16'($urandom_range(65535));
			1: return 16'($urandom_range(127));
			2: return $urandom_range(1) ? CH_MINUS : CH_PLUS;
			default: return digit_char($urandom_range(35));
		endcase
	endfunction

	// send one item; valid stays high so the next item can follow at once
	task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			chars_if.valid <= 1'b0;
			@(posedge clk);
		end
		chars_if.valid     <= 1'b1;
		chars_if.char_code <= ch;
		chars_if.last_char <= last;
		@(posedge clk);
		while (!chars_if.ready)
			@(posedge clk);
		predict_char(ch, last);
		chars_sent++;
	endtask

	task automatic send_chars(input char_q_t s, input logic close);
		for (int i = 0; i < s.size(); i++)
			send_char(s[i], close && i == s.size() - 1);
	endtask

	// stop sending and let every outstanding result come back
	task automatic wait_idle();
		chars_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both registers, in random order, while the parser is idle
	task automatic set_config(input logic [RADIX_W-1:0] r, input logic w);
		logic               idx;
		logic [RADIX_W-1:0] val;
		logic               swap;
		swap = 1'($urandom_range(1));
		for (int k = 0; k < 2; k++) begin
			idx = ((k == 0) != swap) ? REG_RADIX : REG_WIDE_MODE;
			val = (idx == REG_RADIX) ? r : {{(RADIX_W-1){1'b0}}, w};
			cfg_if.valid <= 1'b1;
			cfg_if.index <= idx;
			cfg_if.data  <= val;
			@(posedge clk);
			while (!cfg_if.ready)
				@(posedge clk);
			if (idx == REG_RADIX)
				radix_cfg = val;
			else
				wide_cfg = val[0];
		end
		cfg_if.valid <= 1'b0;
	endtask

	// signed and lone-sign strings at reset settings
	task automatic test_signs_and_lone_signs();
		send_char(CH_PLUS, 1'b0);
		send_char(CH_ZERO + 16'd7, 1'b1);
		send_char(CH_MINUS, 1'b1);
		send_char(CH_PLUS, 1'b1);
	endtask

	// junk first char, sticky error, sign inside, letter above radix, wide code
	task automatic test_illegal_chars();
		send_char(CH_STAR, 1'b0);
		send_char(CH_NINE, 1'b1);
		send_char(CH_ZERO + 16'd5, 1'b0);
		send_char(CH_MINUS, 1'b1);
		send_char(CH_LA, 1'b1);
		send_char(16'hFFFF, 1'b1);
	endtask

	// largest and smallest legal radix
	task automatic test_radix_extremes();
		wait_idle();
		set_config(RADIX_MAX, 1'b0);
		send_char(CH_UZ, 1'b0);
		send_char(CH_LZ, 1'b1);
		wait_idle();
		set_config(RADIX_MIN, 1'b0);
		send_char(CH_MINUS, 1'b0);
		send_char(CH_ZERO + 16'd1, 1'b1);
	endtask

	// radix out of range, also over an illegal char
	task automatic test_bad_radix();
		wait_idle();
		set_config('0, 1'b0);
		send_char(CH_MINUS, 1'b1);
		wait_idle();
		set_config('1, 1'b1);
		send_char(CH_STAR, 1'b1);
	endtask

	// accumulator beyond 32 bits, then mode drops to 32 bits mid-string;
	// a digit then overflows, a non-digit is still an illegal char
	task automatic test_mode_change_mid_string();
		for (int k = 0; k < 2; k++) begin
			wait_idle();
			set_config(RADIX_MAX, 1'b1);
			repeat (6) send_char(CH_LZ, 1'b0);
			wait_idle();
			set_config(RADIX_MAX, 1'b0);
			send_char((k == 0) ? CH_ZERO : CH_BANG, 1'b1);
		end
	endtask

	// one random string: numbers, numbers near the limits, corrupted, noise
	task automatic send_random_string();
		char_q_t     s;
		logic [63:0] base;
		logic [63:0] mag;
		logic [63:0] top;
		int          kind;
		int          sign;
		kind = $urandom_range(99);
		if (kind < 25) begin
			repeat ($urandom_range(1, 6)) s.push_back(noise_char());
			send_chars(s, 1'b1);
			return;
		end
		// 0 no sign, 1 minus, 2 plus
		sign = $urandom_range(2);
		base = (radix_cfg >= RADIX_MIN && radix_cfg <= RADIX_MAX) ? 64'(radix_cfg) : 64'd10;
		if (kind < 40) begin
			if (wide_cfg)
				top = (sign == 1) ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
			else
				top = (sign == 1) ? 64'h8000_0000 : 64'h7FFF_FFFF;
			mag = top - 64'd3 + 64'($urandom_range(6));
		end else if (wide_cfg) begin
			mag = {$urandom, $urandom} >> $urandom_range(63);
		end else begin
			mag = {32'd0, $urandom} >> $urandom_range(31);
		end
		s = number_chars(mag, base);
		if ($urandom_range(7) == 0)
			repeat ($urandom_range(1, 3)) s.push_front(CH_ZERO);
		if (sign == 1)
			s.push_front(CH_MINUS);
		else if (sign == 2)
			s.push_front(CH_PLUS);
		// broken string: one char replaced
		if ($urandom_range(7) == 0)
			s[$urandom_range(s.size() - 1)] = noise_char();
		send_chars(s, 1'b1);
	endtask

	// random strings under random settings, through all idling phases
	task automatic test_random_strings();
		int                 goal;
		logic [RADIX_W-1:0] r;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 72;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 72;
				end
				default: begin
					send_idle_pct  = 12;
					recv_stall_pct = 12;
				end
			endcase
			goal = chars_sent + 450;
			while (chars_sent < goal) begin
				wait_idle();
				case ($urandom_range(9))
					0: r = $urandom_range(1) ? 6'($urandom_range(1)) : 6'($urandom_range(37, 63));
					1: r = RADIX_MIN;
					2: r = RADIX_MAX;
					default: r = 6'($urandom_range(2, 36));
				endcase
				set_config(r, 1'($urandom_range(1)));
				repeat ($urandom_range(4, 12)) send_random_string();
			end
		end
		wait_idle();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	// result channel ready with random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_if.ready <= 1'b0;
		else
			res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// compare each result item with the oldest expected one
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, got value %0d error_code %0d",
					$time, $signed(res_if.value), res_if.error_code);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (res_if.value !== want.value) begin
					$display("%0t: value mismatch: expected %0d, got %0d",
						$time, $signed(want.value), $signed(res_if.value));
					errors++;
				end
				if (res_if.error_code !== want.error_code) begin
					$display("%0t: error_code mismatch: expected %0d, got %0d",
						$time, want.error_code, res_if.error_code);
					errors++;
				end
			end
		end
	end

	// test sequence
	initial begin
		arst_n             <= 1'b0;
		chars_if.valid     <= 1'b0;
		chars_if.char_code <= '0;
		chars_if.last_char <= 1'b0;
		cfg_if.valid       <= 1'b0;
		cfg_if.index       <= REG_RADIX;
		cfg_if.data        <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_signs_and_lone_signs();
		test_illegal_chars();
		test_radix_extremes();
		test_bad_radix();
		test_mode_change_mid_string();
		test_random_strings();
		wait_idle();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/rsti_pkg.sv
rtl/core/rsti_ifs.sv
rtl/core/rsti_decode.sv
rtl/core/rsti_accum.sv
rtl/core/radix_string_to_integer.sv
dv/tb_top.sv
